[hdl/b64d_pkg.sv]
// Shared types, status codes and the alphabet map of the base64 stream decoder.
// Used by b64d_step and base64_stream_decoder_core; depends on nothing.
package b64d_pkg;

  localparam int unsigned SextetW = 6;
  localparam int unsigned StoreW  = 3 * SextetW;
  localparam int unsigned WordW   = 4 * SextetW;
  localparam logic [7:0]  PadChar = 8'h3D;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusBadChar   = 2'd1,
    StatusBadLength = 2'd2,
    StatusBadPad    = 2'd3
  } status_e;

  // Decoder context carried from one character to the next.
  typedef struct packed {
    logic [StoreW-1:0] store;
    logic [1:0]        pos;
    logic              pad_pending;
    logic              padded_seen;
    logic              discarding;
  } state_t;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [1:0] byte_count;
    status_e    status;
    logic       end_of_message;
  } result_t;

  // Maps one character to its sextet; the top bit is set for characters
  // outside the alphabet (padding included).
  function automatic logic [SextetW:0] map_symbol(input logic [7:0] ch);
    logic [SextetW:0] sx;
    sx = {1'b1, {SextetW{1'b0}}};
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      sx = {1'b0, 6'(ch - 8'h41)};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      sx = {1'b0, 6'(ch - 8'h61 + 8'd26)};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      sx = {1'b0, 6'(ch - 8'h30 + 8'd52)};
    end else if (ch == 8'h2B) begin
      sx = {1'b0, 6'd62};
    end else if (ch == 8'h2F) begin
      sx = {1'b0, 6'd63};
    end
    return sx;
  endfunction

endpackage

[hdl/base64_stream_decoder_core.sv]
// Top level of the streaming base64 decoder: context register and result register.
// Depends on b64d_pkg and b64d_step.
//
// Usage: one character of base64 text arrives per transfer on the slave side,
// with tlast on the final character of a message. Every completed quad gives
// one transfer on the master side carrying one to three bytes; tlast there
// marks the last quad of a message or an error result. tuser carries the
// status: ok, invalid character, bad length or misplaced padding. After an
// error the decoder drops characters without results up to and including the
// next one with tlast set.
// Throughput is one character per cycle while the master side does not stall.
// A result appears on the master side in the cycle after the transfer of the
// character that completes the quad; the decode is one pass of table lookup
// and shift between the context register and the result register.
// Reset clears the context, the discard flag and the result register, so the
// block starts at the first character of a fresh message. When the receiver
// stalls, the pending result holds and s_axis_tready_o falls only while that
// result waits and is not being taken in the same cycle.
module base64_stream_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] byte_first, [15:8] byte_second,
                                        // [23:16] byte_third, [25:24] byte_count
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  output logic        m_axis_tlast_o    // end_of_message
);

  b64d_pkg::state_t  state_q, state_d;
  b64d_pkg::result_t res_q, res_d;
  logic              res_valid;
  logic              out_valid_q, out_valid_d;
  logic              in_xfer;

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;

  b64d_step u_step (
    .state_i     (state_q),
    .symbol_i    (s_axis_tdata_i),
    .eot_i       (s_axis_tlast_i),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  always_comb begin
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    if (in_xfer && res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        state_q <= state_d;
      end
      if (in_xfer && res_valid) begin
        res_q <= res_d;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, res_q.byte_count, res_q.byte_third,
                            res_q.byte_second, res_q.byte_first};
  assign m_axis_tuser_o  = res_q.status;
  assign m_axis_tlast_o  = res_q.end_of_message;

endmodule

[hdl/b64d_step.sv]
// Combinational next-state and result logic for one character of base64 text.
// Depends on b64d_pkg.
module b64d_step (
  input  b64d_pkg::state_t  state_i,
  input  logic [7:0]        symbol_i,
  input  logic              eot_i,
  output b64d_pkg::state_t  state_o,
  output logic              res_valid_o,
  output b64d_pkg::result_t res_o
);

  always_comb begin
    logic [b64d_pkg::SextetW:0] sx;
    logic [b64d_pkg::WordW-1:0] word;
    logic [1:0]                 count;
    logic                       fail;
    b64d_pkg::status_e          fail_code;
    logic                       emit;

    sx        = b64d_pkg::map_symbol(symbol_i);
    word      = {state_i.store, sx[b64d_pkg::SextetW-1:0]};
    count     = 2'd3;
    fail      = 1'b0;
    fail_code = b64d_pkg::StatusOk;
    emit      = 1'b0;
    state_o   = state_i;

    if (state_i.discarding) begin
      if (eot_i) begin
        state_o = '0;
      end
    end else if (state_i.padded_seen) begin
      fail      = 1'b1;
      fail_code = b64d_pkg::StatusBadPad;
    end else if (symbol_i == b64d_pkg::PadChar) begin
      if (state_i.pos < 2'd2) begin
        fail      = 1'b1;
        fail_code = b64d_pkg::StatusBadPad;
      end else if (state_i.pos == 2'd2) begin
        if (eot_i) begin
          fail      = 1'b1;
          fail_code = b64d_pkg::StatusBadLength;
        end else begin
          state_o.store       = {state_i.store[b64d_pkg::StoreW-b64d_pkg::SextetW-1:0],
                                 {b64d_pkg::SextetW{1'b0}}};
          state_o.pos         = 2'd3;
          state_o.pad_pending = 1'b1;
        end
      end else begin
        // The fourth place is padding: the leftover low bits are dropped.
        word              = {state_i.store, {b64d_pkg::SextetW{1'b0}}};
        count             = state_i.pad_pending ? 2'd1 : 2'd2;
        emit              = 1'b1;
        state_o           = '0;
        state_o.padded_seen = ~eot_i;
      end
    end else if (sx[b64d_pkg::SextetW]) begin
      fail      = 1'b1;
      fail_code = b64d_pkg::StatusBadChar;
    end else if (state_i.pad_pending) begin
      fail      = 1'b1;
      fail_code = b64d_pkg::StatusBadPad;
    end else if (state_i.pos < 2'd3) begin
      if (eot_i) begin
        fail      = 1'b1;
        fail_code = b64d_pkg::StatusBadLength;
      end else begin
        state_o.store = {state_i.store[b64d_pkg::StoreW-b64d_pkg::SextetW-1:0],
                         sx[b64d_pkg::SextetW-1:0]};
        state_o.pos   = state_i.pos + 2'd1;
      end
    end else begin
      count   = 2'd3;
      emit    = 1'b1;
      state_o = '0;
    end

    if (fail) begin
      state_o            = '0;
      state_o.discarding = ~eot_i;
    end

    res_valid_o        = fail | emit;
    res_o.byte_first   = emit ? word[23:16] : 8'h00;
    res_o.byte_second  = (emit && count >= 2'd2) ? word[15:8] : 8'h00;
    res_o.byte_third   = (emit && count == 2'd3) ? word[7:0] : 8'h00;
    res_o.byte_count   = emit ? count : 2'd0;
    res_o.status       = fail ? fail_code : b64d_pkg::StatusOk;
    res_o.end_of_message = fail | eot_i;
  end

endmodule

[sim/tb_base64_stream_decoder_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_decoder_core: directed and random base64 text,
// random gaps on both stream sides, results checked against a decoder model kept here.
// Depends on b64d_pkg and the decoder RTL.
module tb_base64_stream_decoder_core;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LiveTarget = 340;

  // Decoder context as the testbench tracks it.
  typedef struct packed {
    logic [17:0] store;
    logic [1:0]  pos;
    logic        pad_pending;
    logic        padded_seen;
    logic        discarding;
  } dec_ctx_t;

  typedef struct packed {
    logic [7:0]          b0;
    logic [7:0]          b1;
    logic [7:0]          b2;
    logic [1:0]          count;
    b64d_pkg::status_e   status;
    logic                eom;
  } quad_out_t;

  typedef struct packed {
    dec_ctx_t  ctx;
    quad_out_t res;
    logic      hit;
  } dec_step_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       eot;
    logic       wait_idle;
  } char_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'd0;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;

  char_item_t  pending_q[$];
  quad_out_t   expected_q[$];
  char_item_t  on_bus;
  dec_ctx_t    model_ctx = '0;
  dec_ctx_t    gen_ctx = '0;
  dec_step_t   drv_step;
  logic        drv_next_valid;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  int unsigned live_items = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  base64_stream_decoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [6:0] sextet_of(logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return {1'b0, 6'(ch - "A")};
    if (ch >= "a" && ch <= "z") return {1'b0, 6'(ch - "a" + 8'd26)};
    if (ch >= "0" && ch <= "9") return {1'b0, 6'(ch - "0" + 8'd52)};
    if (ch == "+") return 7'd62;
    if (ch == "/") return 7'd63;
    return 7'h40;
  endfunction

  function automatic logic [7:0] char_of(logic [5:0] v);
    if (v < 6'd26) return 8'("A" + v);
    if (v < 6'd52) return 8'("a" + v - 6'd26);
    if (v < 6'd62) return 8'("0" + v - 6'd52);
    return (v == 6'd62) ? 8'("+") : 8'("/");
  endfunction

  // An error result: the quad is abandoned and, without tlast, the rest of the
  // message is dropped.
  function automatic dec_step_t reject(b64d_pkg::status_e code, logic eot);
    dec_step_t s;
    s = '0;
    s.ctx.discarding = !eot;
    s.hit = 1'b1;
    s.res.status = code;
    s.res.eom = 1'b1;
    return s;
  endfunction

  function automatic dec_step_t predict_char(dec_ctx_t ctx, logic [7:0] ch, logic eot);
    dec_step_t   s;
    logic [6:0]  sx;
    logic [23:0] word;
    s = '0;
    s.ctx = ctx;
    if (ctx.discarding) begin
      if (eot) s.ctx = '0;
      return s;
    end
    if (ctx.padded_seen) return reject(b64d_pkg::StatusBadPad, eot);
    if (ch == b64d_pkg::PadChar) begin
      if (ctx.pos < 2'd2) return reject(b64d_pkg::StatusBadPad, eot);
      if (ctx.pos == 2'd2) begin
        if (eot) return reject(b64d_pkg::StatusBadLength, eot);
        s.ctx.store = {ctx.store[11:0], 6'd0};
        s.ctx.pos = 2'd3;
        s.ctx.pad_pending = 1'b1;
        return s;
      end
      word = {ctx.store, 6'd0};
      s.ctx = '0;
      s.ctx.padded_seen = !eot;
      s.hit = 1'b1;
      s.res.b0 = word[23:16];
      s.res.b1 = ctx.pad_pending ? 8'd0 : word[15:8];
      s.res.count = ctx.pad_pending ? 2'd1 : 2'd2;
      s.res.status = b64d_pkg::StatusOk;
      s.res.eom = eot;
      return s;
    end
    sx = sextet_of(ch);
    if (sx[6]) return reject(b64d_pkg::StatusBadChar, eot);
    if (ctx.pad_pending) return reject(b64d_pkg::StatusBadPad, eot);
    if (ctx.pos != 2'd3) begin
      if (eot) return reject(b64d_pkg::StatusBadLength, eot);
      s.ctx.store = {ctx.store[11:0], sx[5:0]};
      s.ctx.pos = ctx.pos + 2'd1;
      return s;
    end
    word = {ctx.store, sx[5:0]};
    s.ctx = '0;
    s.hit = 1'b1;
    s.res.b0 = word[23:16];
    s.res.b1 = word[15:8];
    s.res.b2 = word[7:0];
    s.res.count = 2'd3;
    s.res.status = b64d_pkg::StatusOk;
    s.res.eom = eot;
    return s;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in steady phases.
  function automatic int unsigned pick_gap(logic steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_char(logic [7:0] ch, logic eot, logic wait_idle);
    dec_step_t s;
    char_item_t it;
    if (!gen_ctx.discarding) live_items++;
    s = predict_char(gen_ctx, ch, eot);
    gen_ctx = s.ctx;
    it.symbol = ch;
    it.eot = eot;
    it.wait_idle = wait_idle;
    pending_q.insert(pending_q.size(), it);
  endtask

  task automatic add_text(string txt, logic eot);
    for (int i = 0; i < txt.len(); i++) begin
      add_char(txt[i], eot && (i == txt.len() - 1), 1'b0);
    end
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Driver: the model is stepped on each accepted character, so expectations
  // are queued in transfer order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= 8'd0;
      s_last  <= 1'b0;
      src_gap <= 0;
    end else begin
      drv_next_valid = s_valid;
      if (s_valid && s_ready) begin
        drv_step = predict_char(model_ctx, on_bus.symbol, on_bus.eot);
        model_ctx = drv_step.ctx;
        if (drv_step.hit) expected_q.insert(expected_q.size(), drv_step.res);
        drv_next_valid = 1'b0;
      end
      if (!drv_next_valid) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].wait_idle && expected_q.size() != 0)) begin
          on_bus = pending_q.pop_front();
          s_data <= on_bus.symbol;
          s_last <= on_bus.eot;
          drv_next_valid = 1'b1;
          src_gap <= pick_gap(cycle_cnt[11:9] == 3'd5);
        end
      end
      s_valid <= drv_next_valid;
    end
  end

  // Monitor and sink stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (m_valid && m_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected, tdata", m_data, 0);
        end else begin
          quad_out_t want;
          want = expected_q.pop_front();
          if (m_data[7:0] != want.b0) report_mismatch("byte_first", m_data[7:0], want.b0);
          if (m_data[15:8] != want.b1) report_mismatch("byte_second", m_data[15:8], want.b1);
          if (m_data[23:16] != want.b2) report_mismatch("byte_third", m_data[23:16], want.b2);
          if (m_data[25:24] != want.count)
            report_mismatch("byte_count", m_data[25:24], want.count);
          if (m_user != want.status) report_mismatch("status", m_user, want.status);
          if (m_last != want.eom) report_mismatch("end_of_message", m_last, want.eom);
        end
      end
      if (snk_gap != 0) begin
        m_ready <= 1'b0;
        snk_gap <= snk_gap - 1;
      end else begin
        m_ready <= 1'b1;
        snk_gap <= pick_gap(cycle_cnt[11:9] == 3'd2);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0]  raw_q[$];
    logic [7:0]  msg_q[$];
    logic [23:0] w;
    int unsigned n;
    int unsigned kind;
    int unsigned cut;
    logic        eot_on_last;
    logic        hold;

    // Directed part: a plain quad, both padding lengths, and each error kind.
    add_text("TWFu", 1'b1);
    add_text("+/9=", 1'b1);
    add_text("az==", 1'b0);   // padded quad without tlast, leftover bits set
    add_text("A", 1'b0);      // rejected as misplaced padding; the rest is dropped
    add_text("Q", 1'b1);      // dropped, ends the discard
    add_char(8'hFF, 1'b0, 1'b0);
    add_char(8'h00, 1'b1, 1'b0);
    add_text("=", 1'b1);
    add_text("Q=", 1'b1);
    add_text("QQ=A", 1'b1);
    add_text("QQ", 1'b1);

    hold = 1'b1;
    live_items = 0;
    while (live_items < LiveTarget) begin
      raw_q.delete();
      msg_q.delete();
      kind = $urandom_range(0, 99);
      if (kind >= 92) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          add_char(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), hold);
          hold = 1'b0;
        end
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
        for (int i = 0; i < n; i++) raw_q.insert(raw_q.size(), 8'($urandom_range(0, 255)));
        for (int i = 0; i < n; i += 3) begin
          w = {raw_q[i], (i + 1 < n) ? raw_q[i + 1] : 8'd0, (i + 2 < n) ? raw_q[i + 2] : 8'd0};
          msg_q.insert(msg_q.size(), char_of(w[23:18]));
          msg_q.insert(msg_q.size(), char_of(w[17:12]));
          msg_q.insert(msg_q.size(), (i + 1 < n) ? char_of(w[11:6]) : b64d_pkg::PadChar);
          msg_q.insert(msg_q.size(), (i + 2 < n) ? char_of(w[5:0]) : b64d_pkg::PadChar);
        end
        eot_on_last = 1'b1;
        if (kind >= 70 && kind < 78) begin
          msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (kind >= 78 && kind < 86) begin
          cut = $urandom_range(1, msg_q.size() - 1);
          while (msg_q.size() > cut) void'(msg_q.pop_back());
        end else if (kind >= 86) begin
          eot_on_last = 1'b0;
        end
        for (int i = 0; i < msg_q.size(); i++) begin
          add_char(msg_q[i], eot_on_last && (i == msg_q.size() - 1), hold);
          hold = 1'b0;
        end
      end
      hold = ($urandom_range(0, 99) < 3);
    end
    // The text may end mid-message; close it so the decoder finishes clean.
    add_text("QUJD", 1'b1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sampled away from the active edge so the driver and monitor have settled.
    while (pending_q.size() != 0 || s_valid) @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_q.size() != 0) report_mismatch("results left outstanding", expected_q.size(), 0);

    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
